// File: src/dsd_pkg.sv
package dsd_pkg;

   // default size of the pattern store in bytes
   localparam int DSD_PATTERN_BYTES = 256;

   // depth of the queues between the parts
   localparam int DSD_QUEUE_DEPTH = 2;

   // parser phases
   typedef enum logic [4:0] {
      PH_COM_HDR   = 5'd0,
      PH_COM_SKIP  = 5'd1,
      PH_TRK       = 5'd2,
      PH_SEC       = 5'd3,
      PH_DLEN      = 5'd4,
      PH_TYPE      = 5'd5,
      PH_SKIP_SIZE = 5'd6,
      PH_SKIP_BAD  = 5'd7,
      PH_RAW       = 5'd8,
      PH_PAIR_HDR  = 5'd9,
      PH_PAIR_REP  = 5'd10,
      PH_RLE_CODE  = 5'd11,
      PH_RLE_COUNT = 5'd12,
      PH_RLE_LIT   = 5'd13,
      PH_RLE_PAT   = 5'd14,
      PH_RLE_REP   = 5'd15,
      PH_END_OK    = 5'd16,
      PH_END_SIZE  = 5'd17,
      PH_END_BAD   = 5'd18,
      PH_DONE      = 5'd19
   } phase_type;

   // result kinds
   localparam logic [2:0] KIND_DATA    = 3'd0;
   localparam logic [2:0] KIND_TRACK   = 3'd1;
   localparam logic [2:0] KIND_SECTOR  = 3'd2;
   localparam logic [2:0] KIND_SEC_END = 3'd3;
   localparam logic [2:0] KIND_IMG_END = 3'd4;
   localparam logic [2:0] KIND_REFUSED = 3'd5;
   localparam logic [2:0] KIND_FORMAT  = 3'd6;

   // sector end status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_SIZE  = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   // stream constants
   localparam logic [7:0] END_OF_IMAGE = 8'hff;
   localparam logic [7:0] CTRL_EMPTY   = 8'h10;
   localparam logic [7:0] SIZE_BAD     = 8'hf8;
   localparam logic [3:0] MAX_PAT_LOG  = 4'd13;

   // input word after classification
   typedef struct packed {
      logic       is_pull;
      logic [7:0] data;
   } item_type;

   // result word
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_out;
      logic [7:0]  cylinder;
      logic [7:0]  side;
      logic [7:0]  sector_number;
      logic [7:0]  size_code;
      logic [15:0] byte_count;
      logic [1:0]  status;
   } rsp_type;

   // build a result word, clearing fields that do not belong to the kind
   function automatic rsp_type make_rsp(
      input logic [2:0]  kind,
      input logic [7:0]  data,
      input logic [1:0]  status,
      input logic [7:0]  trk_cyl,
      input logic [7:0]  trk_side,
      input logic [7:0]  s_cyl,
      input logic [7:0]  s_side,
      input logic [7:0]  s_id,
      input logic [7:0]  s_size,
      input logic [15:0] count
   );
      rsp_type r;
      r = '0;
      r.kind = kind;
      if (kind == KIND_TRACK) begin
         r.cylinder = trk_cyl;
         r.side     = trk_side;
      end else if (kind == KIND_DATA || kind == KIND_SECTOR || kind == KIND_SEC_END ||
                   kind == KIND_FORMAT) begin
         r.cylinder      = s_cyl;
         r.side          = s_side;
         r.sector_number = s_id;
         r.size_code     = s_size;
         if (kind == KIND_DATA) r.data_out = data;
         if (kind == KIND_SEC_END) begin
            r.byte_count = count;
            r.status     = status;
         end
      end
      return r;
   endfunction

   // saturating subtract
   function automatic logic [15:0] sat_sub(input logic [15:0] a, input logic [15:0] b);
      return (a > b) ? (a - b) : 16'd0;
   endfunction

endpackage

// File: src/dsd_fifo.sv
module dsd_fifo
   import dsd_pkg::*;
#(
   parameter int WIDTH = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PW = $clog2(DSD_QUEUE_DEPTH);
   localparam int CW = $clog2(DSD_QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DSD_QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DSD_QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PW'(DSD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PW'(DSD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// File: src/dsd_front.sv
module dsd_front
   import dsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_cmd,
   input  logic [7:0] req_data_in,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_take
);

   item_type in_item;
   logic     q_empty;

   // classify the word: pull or stream byte
   always_comb begin
      in_item.is_pull = req_cmd;
      in_item.data    = req_cmd ? 8'd0 : req_data_in;
   end

   dsd_fifo #(
      .WIDTH($bits(item_type))
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_data(in_item),
      .full   (full),
      .pop    (item_take),
      .empty  (q_empty),
      .rd_data(item)
   );

   assign item_valid = !q_empty;

endmodule

// File: src/dsd_back.sv
module dsd_back
   import dsd_pkg::*;
#(
   parameter int PATTERN_BYTES = DSD_PATTERN_BYTES
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     cfg_we,
   input  logic     cfg_comment,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_take,
   input  logic     out_full,
   output logic     res_valid,
   output rsp_type  res
);

   localparam int PAT_AW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [15:0] skip_left_ff, skip_left_in;
   logic [7:0]  sectors_left_ff, sectors_left_in;
   logic [7:0]  trk_cyl_ff, trk_cyl_in;
   logic [7:0]  trk_side_ff, trk_side_in;
   logic [7:0]  sec_cyl_ff, sec_cyl_in;
   logic [7:0]  sec_side_ff, sec_side_in;
   logic [7:0]  sec_id_ff, sec_id_in;
   logic [7:0]  sec_size_ff, sec_size_in;
   logic [15:0] block_left_ff, block_left_in;
   logic [15:0] run_left_ff, run_left_in;
   logic [15:0] pair_bytes_ff, pair_bytes_in;
   logic [3:0]  pat_log_ff, pat_log_in;
   logic [12:0] pat_pos_ff, pat_pos_in;
   logic [7:0]  repeat_left_ff, repeat_left_in;
   logic [15:0] count_ff, count_in;

   logic [7:0]        store_mem [PATTERN_BYTES];
   logic [7:0]        rd_ff;
   logic              wr_en;
   logic [PAT_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [PAT_AW-1:0] rd_addr;
   logic [7:0]        b;
   logic [7:0]        rep_byte;
   logic [13:0]       pat_size;
   logic              code_bad;
   logic [1:0]        end_status;
   logic              in_end;

   assign item_take = item_valid && !out_full && !cfg_we;
   assign b         = item.data;
   assign pat_size  = 14'd1 << pat_log_ff;
   assign rep_byte  = (32'(pat_pos_ff) < PATTERN_BYTES) ? rd_ff : 8'd0;
   assign code_bad  = (b != 8'd0) &&
                      ((b > 8'(MAX_PAT_LOG)) || ((32'd1 << b[3:0]) > PATTERN_BYTES));
   assign rd_addr   = pat_pos_in[PAT_AW-1:0];

   // main decode step
   always_comb begin
      phase_in        = phase_ff;
      hdr_idx_in      = hdr_idx_ff;
      skip_left_in    = skip_left_ff;
      sectors_left_in = sectors_left_ff;
      trk_cyl_in      = trk_cyl_ff;
      trk_side_in     = trk_side_ff;
      sec_cyl_in      = sec_cyl_ff;
      sec_side_in     = sec_side_ff;
      sec_id_in       = sec_id_ff;
      sec_size_in     = sec_size_ff;
      block_left_in   = block_left_ff;
      run_left_in     = run_left_ff;
      pair_bytes_in   = pair_bytes_ff;
      pat_log_in      = pat_log_ff;
      pat_pos_in      = pat_pos_ff;
      repeat_left_in  = repeat_left_ff;
      count_in        = count_ff;
      res_valid       = 1'b0;
      res             = '0;
      wr_en           = 1'b0;
      wr_addr         = pat_pos_ff[PAT_AW-1:0];
      wr_data         = b;
      end_status      = ST_OK;
      in_end          = 1'b0;

      if (cfg_we) begin
         phase_in   = cfg_comment ? PH_COM_HDR : PH_TRK;
         hdr_idx_in = '0;
      end else if (item_take) begin
         if (item.is_pull) begin
            // pull: drain one pending byte or a waiting sector end
            res_valid = 1'b1;
            if (phase_ff == PH_PAIR_REP) begin
               res = make_rsp(KIND_DATA, rd_ff, ST_OK, trk_cyl_ff, trk_side_ff, sec_cyl_ff,
                              sec_side_ff, sec_id_ff, sec_size_ff, count_ff);
               if (count_ff != 16'hffff) count_in = count_ff + 16'd1;
               if (pat_pos_ff[0]) begin
                  pat_pos_in    = '0;
                  pair_bytes_in = pair_bytes_ff - 16'd1;
                  if (pair_bytes_in == 16'd0) phase_in = PH_END_OK;
               end else begin
                  pat_pos_in = 13'd1;
               end
            end else if (phase_ff == PH_RLE_REP) begin
               res = make_rsp(KIND_DATA, rep_byte, ST_OK, trk_cyl_ff, trk_side_ff,
                              sec_cyl_ff, sec_side_ff, sec_id_ff, sec_size_ff, count_ff);
               if (count_ff != 16'hffff) count_in = count_ff + 16'd1;
               if (14'(pat_pos_ff) + 14'd1 >= pat_size) begin
                  pat_pos_in = '0;
                  if (repeat_left_ff != 8'd0) repeat_left_in = repeat_left_ff - 8'd1;
                  if (repeat_left_in == 8'd0)
                     phase_in = (block_left_ff > 16'd1) ? PH_RLE_CODE : PH_END_OK;
               end else begin
                  pat_pos_in = pat_pos_ff + 13'd1;
               end
            end else if (phase_ff == PH_END_OK || phase_ff == PH_END_SIZE ||
                         phase_ff == PH_END_BAD) begin
               in_end = 1'b1;
            end else begin
               res = make_rsp(KIND_REFUSED, 8'd0, ST_OK, trk_cyl_ff, trk_side_ff, sec_cyl_ff,
                              sec_side_ff, sec_id_ff, sec_size_ff, count_ff);
            end
         end else if (phase_ff == PH_PAIR_REP || phase_ff == PH_RLE_REP ||
                      phase_ff == PH_END_OK || phase_ff == PH_END_SIZE ||
                      phase_ff == PH_END_BAD) begin
            // stream byte while something waits
            res_valid = 1'b1;
            res = make_rsp(KIND_REFUSED, 8'd0, ST_OK, trk_cyl_ff, trk_side_ff, sec_cyl_ff,
                           sec_side_ff, sec_id_ff, sec_size_ff, count_ff);
         end else begin
            // stream byte parse
            unique case (phase_ff)
               PH_COM_HDR: begin
                  if (hdr_idx_ff == 4'd2) skip_left_in = {8'd0, b};
                  if (hdr_idx_ff == 4'd3) skip_left_in = {b, skip_left_ff[7:0]};
                  hdr_idx_in = hdr_idx_ff + 4'd1;
                  if (hdr_idx_in >= 4'd10) begin
                     hdr_idx_in = '0;
                     phase_in   = (skip_left_in != 16'd0) ? PH_COM_SKIP : PH_TRK;
                  end
               end
               PH_COM_SKIP: begin
                  skip_left_in = sat_sub(skip_left_ff, 16'd1);
                  if (skip_left_in == 16'd0) begin
                     phase_in   = PH_TRK;
                     hdr_idx_in = '0;
                  end
               end
               PH_TRK: begin
                  if (hdr_idx_ff == 4'd0) sectors_left_in = b;
                  else if (hdr_idx_ff == 4'd1) trk_cyl_in = b;
                  else if (hdr_idx_ff == 4'd2) trk_side_in = b;
                  hdr_idx_in = hdr_idx_ff + 4'd1;
                  if (hdr_idx_in >= 4'd4) begin
                     hdr_idx_in = '0;
                     res_valid  = 1'b1;
                     if (sectors_left_in == END_OF_IMAGE) begin
                        phase_in = PH_DONE;
                        res = make_rsp(KIND_IMG_END, 8'd0, ST_OK, trk_cyl_in, trk_side_in,
                                       sec_cyl_ff, sec_side_ff, sec_id_ff, sec_size_ff,
                                       count_ff);
                     end else begin
                        phase_in = (sectors_left_in != 8'd0) ? PH_SEC : PH_TRK;
                        res = make_rsp(KIND_TRACK, 8'd0, ST_OK, trk_cyl_in, trk_side_in,
                                       sec_cyl_ff, sec_side_ff, sec_id_ff, sec_size_ff,
                                       count_ff);
                     end
                  end
               end
               PH_SEC: begin
                  case (hdr_idx_ff)
                     4'd0:    sec_cyl_in   = b;
                     4'd1:    sec_side_in  = b;
                     4'd2:    sec_id_in    = b;
                     4'd3:    sec_size_in  = b;
                     4'd4:    skip_left_in = {8'd0, b};
                     default: ;
                  endcase
                  hdr_idx_in = hdr_idx_ff + 4'd1;
                  if (hdr_idx_in >= 4'd6) begin
                     hdr_idx_in = '0;
                     count_in   = '0;
                     if ((skip_left_in[7:0] & CTRL_EMPTY) != 8'd0) begin
                        res_valid = 1'b1;
                        res = make_rsp(KIND_SEC_END, 8'd0, ST_EMPTY, trk_cyl_ff, trk_side_ff,
                                       sec_cyl_in, sec_side_in, sec_id_in, sec_size_in,
                                       16'd0);
                        if (sectors_left_ff != 8'd0) sectors_left_in = sectors_left_ff - 8'd1;
                        phase_in = (sectors_left_in != 8'd0) ? PH_SEC : PH_TRK;
                     end else begin
                        phase_in = PH_DLEN;
                     end
                  end
               end
               PH_DLEN: begin
                  if (hdr_idx_ff == 4'd0) begin
                     block_left_in = {8'd0, b};
                     hdr_idx_in    = 4'd1;
                  end else begin
                     block_left_in = {b, block_left_ff[7:0]};
                     hdr_idx_in    = '0;
                     if ((sec_size_ff & SIZE_BAD) != 8'd0) begin
                        skip_left_in = block_left_in;
                        phase_in = (block_left_in != 16'd0) ? PH_SKIP_SIZE : PH_END_SIZE;
                     end else begin
                        phase_in = PH_TYPE;
                     end
                  end
               end
               PH_TYPE: begin
                  block_left_in = sat_sub(block_left_ff, 16'd1);
                  if (b <= 8'd2) begin
                     res_valid = 1'b1;
                     res = make_rsp(KIND_SECTOR, 8'd0, ST_OK, trk_cyl_ff, trk_side_ff,
                                    sec_cyl_ff, sec_side_ff, sec_id_ff, sec_size_ff,
                                    count_ff);
                  end
                  case (b)
                     8'd0: phase_in = (block_left_in != 16'd0) ? PH_RAW : PH_END_OK;
                     8'd1: begin
                        hdr_idx_in = '0;
                        phase_in   = PH_PAIR_HDR;
                     end
                     8'd2: phase_in = (block_left_in > 16'd1) ? PH_RLE_CODE : PH_END_OK;
                     default: begin
                        skip_left_in = block_left_in;
                        phase_in = (block_left_in != 16'd0) ? PH_SKIP_BAD : PH_END_BAD;
                     end
                  endcase
               end
               PH_SKIP_SIZE, PH_SKIP_BAD: begin
                  skip_left_in = sat_sub(skip_left_ff, 16'd1);
                  if (skip_left_in == 16'd0)
                     phase_in = (phase_ff == PH_SKIP_SIZE) ? PH_END_SIZE : PH_END_BAD;
               end
               PH_RAW: begin
                  res_valid = 1'b1;
                  res = make_rsp(KIND_DATA, b, ST_OK, trk_cyl_ff, trk_side_ff, sec_cyl_ff,
                                 sec_side_ff, sec_id_ff, sec_size_ff, count_ff);
                  if (count_ff != 16'hffff) count_in = count_ff + 16'd1;
                  block_left_in = sat_sub(block_left_ff, 16'd1);
                  if (block_left_in == 16'd0) phase_in = PH_END_OK;
               end
               PH_PAIR_HDR: begin
                  if (hdr_idx_ff == 4'd0) begin
                     pair_bytes_in = {8'd0, b};
                  end else if (hdr_idx_ff == 4'd1) begin
                     pair_bytes_in = {b, pair_bytes_ff[7:0]};
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = (hdr_idx_ff == 4'd2) ? PAT_AW'(0) : PAT_AW'(1);
                  end
                  hdr_idx_in = hdr_idx_ff + 4'd1;
                  if (hdr_idx_in >= 4'd4) begin
                     hdr_idx_in = '0;
                     pat_pos_in = '0;
                     phase_in   = (pair_bytes_ff != 16'd0) ? PH_PAIR_REP : PH_END_OK;
                  end
               end
               PH_RLE_CODE: begin
                  block_left_in = sat_sub(block_left_ff, 16'd1);
                  if (code_bad) begin
                     res_valid = 1'b1;
                     res = make_rsp(KIND_FORMAT, 8'd0, ST_OK, trk_cyl_ff, trk_side_ff,
                                    sec_cyl_ff, sec_side_ff, sec_id_ff, sec_size_ff,
                                    count_ff);
                     skip_left_in = block_left_in;
                     phase_in = (block_left_in != 16'd0) ? PH_SKIP_BAD : PH_END_BAD;
                  end else begin
                     pat_log_in = b[3:0];
                     phase_in   = PH_RLE_COUNT;
                  end
               end
               PH_RLE_COUNT: begin
                  block_left_in  = sat_sub(block_left_ff, 16'd1);
                  repeat_left_in = b;
                  if (pat_log_ff == 4'd0) begin
                     run_left_in   = {8'd0, b};
                     block_left_in = sat_sub(block_left_in, {8'd0, b});
                     if (b != 8'd0) phase_in = PH_RLE_LIT;
                     else phase_in = (block_left_in > 16'd1) ? PH_RLE_CODE : PH_END_OK;
                  end else begin
                     run_left_in   = {2'd0, pat_size};
                     block_left_in = sat_sub(block_left_in, run_left_in);
                     pat_pos_in    = '0;
                     phase_in      = PH_RLE_PAT;
                  end
               end
               PH_RLE_LIT: begin
                  res_valid = 1'b1;
                  res = make_rsp(KIND_DATA, b, ST_OK, trk_cyl_ff, trk_side_ff, sec_cyl_ff,
                                 sec_side_ff, sec_id_ff, sec_size_ff, count_ff);
                  if (count_ff != 16'hffff) count_in = count_ff + 16'd1;
                  run_left_in = sat_sub(run_left_ff, 16'd1);
                  if (run_left_in == 16'd0)
                     phase_in = (block_left_ff > 16'd1) ? PH_RLE_CODE : PH_END_OK;
               end
               PH_RLE_PAT: begin
                  wr_en       = (32'(pat_pos_ff) < PATTERN_BYTES);
                  pat_pos_in  = pat_pos_ff + 13'd1;
                  run_left_in = sat_sub(run_left_ff, 16'd1);
                  if (run_left_in == 16'd0) begin
                     pat_pos_in = '0;
                     if (repeat_left_ff != 8'd0) phase_in = PH_RLE_REP;
                     else phase_in = (block_left_ff > 16'd1) ? PH_RLE_CODE : PH_END_OK;
                  end
               end
               default: ;
            endcase
            if (!res_valid && (phase_in == PH_END_OK || phase_in == PH_END_SIZE ||
                               phase_in == PH_END_BAD)) begin
               res_valid = 1'b1;
               in_end    = 1'b1;
            end
         end

         // sector end closes the sector and moves on
         if (in_end) begin
            end_status = (phase_in == PH_END_SIZE) ? ST_SIZE :
                         (phase_in == PH_END_BAD) ? ST_BAD : ST_OK;
            res = make_rsp(KIND_SEC_END, 8'd0, end_status, trk_cyl_in, trk_side_in,
                           sec_cyl_in, sec_side_in, sec_id_in, sec_size_in, count_in);
            if (sectors_left_in != 8'd0) sectors_left_in = sectors_left_in - 8'd1;
            phase_in   = (sectors_left_in != 8'd0) ? PH_SEC : PH_TRK;
            hdr_idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TRK;
         hdr_idx_ff      <= '0;
         skip_left_ff    <= '0;
         sectors_left_ff <= '0;
         trk_cyl_ff      <= '0;
         trk_side_ff     <= '0;
         sec_cyl_ff      <= '0;
         sec_side_ff     <= '0;
         sec_id_ff       <= '0;
         sec_size_ff     <= '0;
         block_left_ff   <= '0;
         run_left_ff     <= '0;
         pair_bytes_ff   <= '0;
         pat_log_ff      <= '0;
         pat_pos_ff      <= '0;
         repeat_left_ff  <= '0;
         count_ff        <= '0;
      end else begin
         phase_ff        <= phase_in;
         hdr_idx_ff      <= hdr_idx_in;
         skip_left_ff    <= skip_left_in;
         sectors_left_ff <= sectors_left_in;
         trk_cyl_ff      <= trk_cyl_in;
         trk_side_ff     <= trk_side_in;
         sec_cyl_ff      <= sec_cyl_in;
         sec_side_ff     <= sec_side_in;
         sec_id_ff       <= sec_id_in;
         sec_size_ff     <= sec_size_in;
         block_left_ff   <= block_left_in;
         run_left_ff     <= run_left_in;
         pair_bytes_ff   <= pair_bytes_in;
         pat_log_ff      <= pat_log_in;
         pat_pos_ff      <= pat_pos_in;
         repeat_left_ff  <= repeat_left_in;
         count_ff        <= count_in;
      end
   end

   // pattern store, read ahead at the next position
   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) rd_ff <= wr_data;
      else rd_ff <= store_mem[rd_addr];
   end

`ifndef NO_ASSERTIONS
   a_pair_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAIR_REP |-> pat_pos_ff <= 13'd1)
      else $error("pair position out of range");

   a_rep_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RLE_REP |-> 32'(pat_pos_ff) < PATTERN_BYTES)
      else $error("pattern position beyond store");

   a_refuse: assert property (@(posedge clock) disable iff (reset)
      item_take && !item.is_pull && !cfg_we &&
      (phase_ff == PH_PAIR_REP || phase_ff == PH_RLE_REP)
      |-> res_valid && res.kind == KIND_REFUSED)
      else $error("stream byte not refused while repeats pending");

   a_res_take: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> item_take && !out_full)
      else $error("result without a taken word");
`endif

endmodule

// File: src/disk_image_sector_decoder_core.sv
// Sector decoder for the body of a track-image file stream.
// Input queue: drive req_cmd/req_data_in with push; a word is taken at a
// clock edge where push is high and full is low. req_cmd 0 carries a stream
// byte, 1 pulls one pending expanded byte or a waiting sector end.
// Result queue: while empty is low the oldest result sits on the rsp_ ports;
// pop takes it. Each input word gives zero or one result word.
// Configuration: APB-style write of comment_present at address 0 restarts
// parsing; write only while the block is idle.
// Throughput: one word per cycle while out_full and cfg_we are low, set by the
// single decode step in the back end, which reads the pattern store one byte
// ahead and pushes each result into the result queue as it takes the word.
// A two-entry queue sits between the front and the back end and another in
// front of the result ports; when pop stays low the result queue fills, the
// back end holds, and full rises once the input queue fills.
// Reset (synchronous, active high) empties both queues, clears the parser
// and comment_present; the pattern store is not cleared and needs no sweep.
module disk_image_sector_decoder_core
   import dsd_pkg::*;
#(
   parameter int PATTERN_BYTES = DSD_PATTERN_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_in,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_out,
   output logic [7:0]  rsp_cylinder,
   output logic [7:0]  rsp_side,
   output logic [7:0]  rsp_sector_number,
   output logic [7:0]  rsp_size_code,
   output logic [15:0] rsp_byte_count,
   output logic [1:0]  rsp_status,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic     comment_ff, comment_in;
   logic     cfg_we;
   logic     item_valid, item_take;
   item_type item;
   logic     out_full, res_valid;
   rsp_type  res, rsp;

   // configuration register
   assign pready     = 1'b1;
   assign cfg_we     = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
   assign comment_in = cfg_we ? pwdata[0] : comment_ff;
   assign prdata     = (paddr[2] == 1'b0) ? {31'd0, comment_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) comment_ff <= 1'b0;
      else comment_ff <= comment_in;
   end

   dsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_cmd    (req_cmd),
      .req_data_in(req_data_in),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   dsd_back #(
      .PATTERN_BYTES(PATTERN_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_we     (cfg_we),
      .cfg_comment(pwdata[0]),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_full   (out_full),
      .res_valid  (res_valid),
      .res        (res)
   );

   // result queue
   dsd_fifo #(
      .WIDTH($bits(rsp_type))
   ) u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (res_valid),
      .wr_data(res),
      .full   (out_full),
      .pop    (pop),
      .empty  (empty),
      .rd_data(rsp)
   );

   assign rsp_kind          = rsp.kind;
   assign rsp_data_out      = rsp.data_out;
   assign rsp_cylinder      = rsp.cylinder;
   assign rsp_side          = rsp.side;
   assign rsp_sector_number = rsp.sector_number;
   assign rsp_size_code     = rsp.size_code;
   assign rsp_byte_count    = rsp.byte_count;
   assign rsp_status        = rsp.status;

endmodule
